// ----- sv/mfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfp_pkg: shared types and constants for the frame store plotter
// Payload structs, operation and color codes, controller/datapath link.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int STORE_BYTES      = 1024;
    localparam int ADDR_W           = 10;

    localparam logic [1:0] OP_PLOT = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_TAKE = 2'd3;

    localparam logic [1:0] COL_CLEAR  = 2'd0;
    localparam logic [1:0] COL_SET    = 2'd1;
    localparam logic [1:0] COL_INVERT = 2'd2;

    localparam logic [0:0] CFG_ROTATION = 1'd0;
    localparam logic [0:0] CFG_INVERT   = 1'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [1:0]         color;
        logic [9:0]         byte_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [6:0] box_left;
        logic [6:0] box_right;
        logic [5:0] box_top;
        logic [5:0] box_bottom;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, compute clipped box
        logic clr_step;  // advance clear sweep
        logic rd;        // issue store read for current byte
        logic wr;        // write back modified byte
        logic advance;   // step to next byte of fill
        logic take;      // latch box result and empty box
        logic rdout;     // latch read result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic empty;     // clipped op draws nothing
        logic last;      // current byte is the last of the walk
        logic [1:0] op;
    } t_sts;

endpackage

// ----- sv/mono_framebuffer_plotter_unit.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_plotter_unit: 128x64 one-bit frame store with dirty box
// Per transaction: take latches the box, read reads one byte, plot and fill
// read, modify and write each byte; a plot or fill clipped to nothing skips these.
// One transaction at a time: a new item is taken only while the controller is idle.
// Reset: a clearing pass writes every store byte to zero before ready rises.
// Dirty box resets to full screen; rotation and invert reset to 0.
// ----------------------------------------------------------------------------
module mono_framebuffer_plotter_unit #(
    parameter int PANEL_WIDTH  = mfp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mfp_pkg::PANEL_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mfp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mfp_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [1:0]         i_cfg_data
);
    import mfp_pkg::*;

    logic [1:0] r_rotation;
    logic       r_invert;
    t_cmd       w_cmd;
    t_sts       w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= '0;
            r_invert   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROTATION: r_rotation <= i_cfg_data;
                CFG_INVERT:   r_invert   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mfp_dp #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_in_data),
        .i_rotation(r_rotation),
        .i_invert  (r_invert),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_item    (o_out_data)
    );
endmodule

// ----- sv/mfp_ram.sv -----
// ----------------------------------------------------------------------------
// mfp_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/mfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfp_ctrl: operation sequencer
// Clears the store after reset, then runs each item to result handoff: take
// latches the box, read reads a byte, plot and fill read-modify-write bytes.
// ----------------------------------------------------------------------------
module mfp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mfp_pkg::t_sts i_sts,
    output mfp_pkg::t_cmd o_cmd
);
    import mfp_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_WR    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.op)
                    OP_TAKE: begin
                        o_cmd.take = 1'b1;
                        n_state    = S_OUT;
                    end
                    default: begin
                        if (i_sts.op != OP_READ && i_sts.empty) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.rd = 1'b1;
                            n_state  = S_WAIT;
                        end
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.op == OP_READ) begin
                    o_cmd.rdout = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.last) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- sv/mfp_dp.sv -----
// ----------------------------------------------------------------------------
// mfp_dp: clip, rotate, byte walk and dirty box datapath
// Holds the frame store, the walk counters and the dirty box.
// ----------------------------------------------------------------------------
module mfp_dp #(
    parameter int PANEL_WIDTH  = mfp_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mfp_pkg::PANEL_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfp_pkg::t_in_item  i_item,
    input  logic [1:0]         i_rotation,
    input  logic               i_invert,
    input  mfp_pkg::t_cmd      i_cmd,
    output mfp_pkg::t_sts      o_sts,
    output mfp_pkg::t_out_item o_item
);
    import mfp_pkg::*;

    localparam int XW = $clog2(PANEL_WIDTH);
    localparam int YW = $clog2(PANEL_HEIGHT);

    // captured item
    logic [1:0]      r_op, r_color;
    logic [9:0]      r_baddr;
    logic [XW-1:0]   r_px0, r_px1;   // physical first/last column
    logic [YW-1:0]   r_py1;          // physical last row
    logic            r_empty;
    logic [XW-4:0]   r_bcol;         // current byte column
    logic [YW-1:0]   r_row;
    logic [ADDR_W:0] r_clr;
    logic [XW-1:0]   r_dl, r_dr;
    logic [YW-1:0]   r_dt, r_db;
    t_out_item       r_out;

    // ---- clip and rotate (combinational from the input item) ----
    logic signed [17:0] c_x, c_y, c_w, c_h, c_lw, c_lh, c_x0, c_y0;
    logic signed [17:0] c_x1, c_y1;  // inclusive logical ends
    logic               c_empty;
    logic signed [17:0] c_a0, c_a1, c_b0, c_b1;
    logic [XW-1:0]      c_px0, c_px1;
    logic [YW-1:0]      c_py0, c_py1;

    always_comb begin
        c_x  = 18'(i_item.x_pos);
        c_y  = 18'(i_item.y_pos);
        c_lw = i_rotation[0] ? 18'(PANEL_HEIGHT) : 18'(PANEL_WIDTH);
        c_lh = i_rotation[0] ? 18'(PANEL_WIDTH) : 18'(PANEL_HEIGHT);
        if (i_item.operation == OP_PLOT) begin
            c_w = 18'sd1;
            c_h = 18'sd1;
        end else begin
            c_w = 18'(i_item.rect_width);
            c_h = 18'(i_item.rect_height);
        end
        c_x0 = c_x;
        c_y0 = c_y;
        if (c_x < 0) begin
            c_w  = c_w + c_x;
            c_x0 = '0;
        end
        if (c_y < 0) begin
            c_h  = c_h + c_y;
            c_y0 = '0;
        end
        if (c_x0 + c_w > c_lw) c_w = c_lw - c_x0;
        if (c_y0 + c_h > c_lh) c_h = c_lh - c_y0;
        c_empty = (c_x >= c_lw) || (c_y >= c_lh) || (c_w <= 0) || (c_h <= 0);
        c_x1 = c_x0 + c_w - 18'sd1;
        c_y1 = c_y0 + c_h - 18'sd1;
        c_a0 = c_x0; c_a1 = c_x1; c_b0 = c_y0; c_b1 = c_y1;
        case (i_rotation)
            2'd1: begin
                c_a0 = 18'(PANEL_WIDTH - 1) - c_y1; c_a1 = 18'(PANEL_WIDTH - 1) - c_y0;
                c_b0 = c_x0; c_b1 = c_x1;
            end
            2'd2: begin
                c_a0 = 18'(PANEL_WIDTH - 1) - c_x1; c_a1 = 18'(PANEL_WIDTH - 1) - c_x0;
                c_b0 = 18'(PANEL_HEIGHT - 1) - c_y1; c_b1 = 18'(PANEL_HEIGHT - 1) - c_y0;
            end
            2'd3: begin
                c_a0 = c_y0; c_a1 = c_y1;
                c_b0 = 18'(PANEL_HEIGHT - 1) - c_x1; c_b1 = 18'(PANEL_HEIGHT - 1) - c_x0;
            end
            default: ;
        endcase
        c_px0 = c_a0[XW-1:0];
        c_px1 = c_a1[XW-1:0];
        c_py0 = c_b0[YW-1:0];
        c_py1 = c_b1[YW-1:0];
    end

    // ---- byte address and mask of the current walk position ----
    logic [ADDR_W-1:0] c_addr;
    logic [7:0]        c_mask, c_lo_m, c_hi_m, c_rdata, c_next;
    logic [XW-1:0]     c_col;
    logic              c_first_b, c_last_b, c_changed;

    always_comb begin
        c_first_b = (r_bcol == r_px0[XW-1:3]);
        c_last_b  = (r_bcol == r_px1[XW-1:3]);
        c_lo_m    = c_first_b ? (8'hFF >> r_px0[2:0]) : 8'hFF;
        c_hi_m    = c_last_b ? (8'hFF << (3'd7 - r_px1[2:0])) : 8'hFF;
        c_mask    = c_lo_m & c_hi_m;
        c_addr    = {r_row[YW-2:0], r_row[YW-1], r_bcol};
        // fill uses start column plus byte offset; equals px0 for plot
        c_col     = r_px0 + {(r_bcol - r_px0[XW-1:3]), 3'b000};
    end

    always_comb begin
        case (r_color)
            COL_SET:    c_next = c_rdata | c_mask;
            COL_INVERT: c_next = c_rdata ^ c_mask;
            COL_CLEAR:  c_next = c_rdata & ~c_mask;
            default:    c_next = (r_op == OP_PLOT) ? c_rdata : (c_rdata & ~c_mask);
        endcase
        c_changed = (c_next != c_rdata);
    end

    // ---- frame store ----
    logic              c_we;
    logic [ADDR_W-1:0] c_ram_addr;
    logic [7:0]        c_wdata;

    always_comb begin
        if (!r_clr[ADDR_W]) begin
            c_we       = 1'b1;
            c_ram_addr = r_clr[ADDR_W-1:0];
            c_wdata    = '0;
        end else begin
            c_we       = i_cmd.wr;
            c_ram_addr = (r_op == OP_READ) ? r_baddr : c_addr;
            c_wdata    = c_next;
        end
    end

    mfp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_addr (c_ram_addr),
        .i_wdata(c_wdata),
        .o_rdata(c_rdata)
    );

    // ---- control registers: clear sweep and dirty box ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_dl  <= '0;
            r_dr  <= XW'(PANEL_WIDTH - 1);
            r_dt  <= '0;
            r_db  <= YW'(PANEL_HEIGHT - 1);
        end else begin
            if (i_cmd.clr_step && !r_clr[ADDR_W]) r_clr <= r_clr + 1'b1;
            if (i_cmd.wr && c_changed) begin
                if (c_col < r_dl) r_dl <= c_col;
                if (c_col > r_dr) r_dr <= c_col;
                if (r_row < r_dt) r_dt <= r_row;
                if (r_row > r_db) r_db <= r_row;
            end
            if (i_cmd.take) begin
                r_dl <= XW'(PANEL_WIDTH - 1);
                r_dr <= '0;
                r_dt <= YW'(PANEL_HEIGHT - 1);
                r_db <= '0;
            end
        end
    end

    // ---- item registers and walk counters ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_item.operation;
            r_color <= i_item.color;
            r_baddr <= i_item.byte_address;
            r_px0   <= c_px0;
            r_px1   <= c_px1;
            r_py1   <= c_py1;
            r_empty <= c_empty;
            r_bcol  <= c_px0[XW-1:3];
            r_row   <= c_py0;
            r_out   <= '0;
        end else begin
            if (i_cmd.advance) begin
                if (c_last_b) begin
                    r_bcol <= r_px0[XW-1:3];
                    r_row  <= r_row + 1'b1;
                end else begin
                    r_bcol <= r_bcol + 1'b1;
                end
            end
            if (i_cmd.rdout) r_out.read_data <= c_rdata ^ {8{i_invert}};
            if (i_cmd.take) begin
                r_out.box_left   <= (r_dr < r_dl) ? '0 : r_dl;
                r_out.box_right  <= (r_dr < r_dl) ? XW'(PANEL_WIDTH - 1) : r_dr;
                r_out.box_top    <= (r_db < r_dt) ? '0 : r_dt;
                r_out.box_bottom <= (r_db < r_dt) ? YW'(PANEL_HEIGHT - 1) : r_db;
            end
        end
    end

    assign o_sts.clr_done = r_clr[ADDR_W];
    assign o_sts.empty    = r_empty;
    assign o_sts.last     = c_last_b && (r_row == r_py1);
    assign o_sts.op       = r_op;
    assign o_item         = r_out;
endmodule

// ----- sv/mfp_checker.sv -----
// ----------------------------------------------------------------------------
// mfp_checker: port-level checks for the plotter
// Handshake and result-field checks, bound to the top level.
// ----------------------------------------------------------------------------
module mfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mfp_pkg::t_out_item o_out_data
);
    // one transaction in flight: never ready while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready with result pending");

    // no result is valid in the cycle after an item is accepted
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid) else $error("result too early");

    // pending result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped");

    // a result carries either read data or a box, never both
    a_excl_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.read_data != 8'd0) |->
        (o_out_data.box_right == 7'd0 && o_out_data.box_bottom == 6'd0))
        else $error("mixed result fields");
endmodule

bind mono_framebuffer_plotter_unit mfp_checker u_mfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
